// ----- design/lwfs_pkg.sv -----
// shared types and constants for the lcd window fill serializer
`default_nettype none

package lwfs_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // color format codes; the unused code behaves as 18-bit
    localparam logic [1:0] FMT_12 = 2'd0;
    localparam logic [1:0] FMT_16 = 2'd1;
    localparam logic [1:0] FMT_18 = 2'd2;
    localparam logic [1:0] FMT_RESET = FMT_16;

    // controller commands
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    // header phases, one per byte, then the pixel stream
    localparam logic [3:0] PHASE_CASET  = 4'd0;
    localparam logic [3:0] PHASE_XS_HI  = 4'd1;
    localparam logic [3:0] PHASE_XS_LO  = 4'd2;
    localparam logic [3:0] PHASE_XE_HI  = 4'd3;
    localparam logic [3:0] PHASE_XE_LO  = 4'd4;
    localparam logic [3:0] PHASE_RASET  = 4'd5;
    localparam logic [3:0] PHASE_YS_HI  = 4'd6;
    localparam logic [3:0] PHASE_YS_LO  = 4'd7;
    localparam logic [3:0] PHASE_YE_HI  = 4'd8;
    localparam logic [3:0] PHASE_YE_LO  = 4'd9;
    localparam logic [3:0] PHASE_RAMWR  = 4'd10;
    localparam logic [3:0] PHASE_PIXELS = 4'd11;

    typedef struct packed {
        logic       op;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    typedef struct packed {
        logic serial_bit;
        logic is_data;
        logic last;
    } result_t;

    // classified request as it waits in the queue
    typedef struct packed {
        item_t       item;
        logic [15:0] pixel_count;
    } cmd_t;

endpackage

`default_nettype wire

// ----- design/lcd_window_fill_serializer.sv -----
// top level of the serial tft rectangle fill serializer
`default_nettype none

// Serializes a rectangle fill for a serial TFT controller. A load request
// latches the window corners and a color; each tick request that follows
// yields one serial bit with its data/command flag, through the CASET, RASET
// and RAMWR headers and then the pixel stream, with last on the final bit.
// Loads and ticks while idle yield no result. One request is taken every
// clock while item_stall is low; a request passes a front register (where
// the 16-bit pixel count of a load is multiplied out), a QUEUE_DEPTH entry
// command queue and the serializer, which registers its bit on the output
// register. The queue absorbs output stalls before requests are refused.
// The color format register may be written only while the block is idle.
module lcd_window_fill_serializer
    import lwfs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire item_t      item,
    output logic            result_valid,
    input  wire logic       result_stall,
    output result_t         result,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic queue_empty;
    logic pop;
    cmd_t head;

    lwfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    lwfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    lwfs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .queue_empty  (queue_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- design/lwfs_front.sv -----
// front stage: takes requests and works out the pixel count of a load
`default_nettype none

module lwfs_front
    import lwfs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    output logic       push,
    output cmd_t       push_cmd,
    input  wire logic  queue_full
);

    logic        front_valid_reg;
    logic        front_valid_next;
    cmd_t        front_cmd_reg;
    logic        accept;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] area;

    assign push       = front_valid_reg && !queue_full;
    assign item_stall = front_valid_reg && queue_full;
    assign accept     = item_valid && !item_stall;
    assign push_cmd   = front_cmd_reg;

    // counts wrap at 16 bits, reversed corners included
    assign width  = {8'd0, item.x_end} - {8'd0, item.x_start} + 16'd1;
    assign height = {8'd0, item.y_end} - {8'd0, item.y_start} + 16'd1;
    assign area   = width * height;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_cmd_reg.item        <= item;
            front_cmd_reg.pixel_count <= area[15:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/lwfs_queue.sv -----
// short command queue between the front stage and the serializer
`default_nettype none

module lwfs_queue
    import lwfs_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- design/lwfs_back.sv -----
// serializer: runs the header and pixel sequence and holds the output register
`default_nettype none

module lwfs_back
    import lwfs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    input  wire logic       queue_empty,
    input  wire cmd_t       head,
    output logic            pop,
    output logic            result_valid,
    input  wire logic       result_stall,
    output result_t         result
);

    logic [1:0]  color_format_reg;
    logic        busy_reg;
    logic        busy_next;
    logic [3:0]  phase_reg;
    logic [3:0]  phase_next;
    logic [4:0]  bit_pos_reg;
    logic [4:0]  bit_pos_next;
    logic [15:0] pixels_left_reg;
    logic [15:0] pixels_left_next;
    logic [31:0] corners_reg;
    logic [31:0] corners_next;
    logic [23:0] color_reg;
    logic [23:0] color_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    result_t     result_reg;
    result_t     result_next;

    logic        emit;
    logic [7:0]  hdr_byte;
    logic [2:0]  hdr_pos;
    logic [4:0]  pixel_len;
    logic [5:0]  pos_inc;
    logic [15:0] pixels_dec;

    function automatic logic pixel_bit(input logic [1:0] fmt, input logic [4:0] pos,
                                       input logic [23:0] color);
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [2:0] k;
        logic [4:0] off;
        logic       b;
        blue  = color[7:0];
        green = color[15:8];
        red   = color[23:16];
        k     = pos[2:0];
        off   = '0;
        b     = 1'b0;
        case (fmt)
            FMT_12:
            begin
                if (pos < 5'd12)
                begin
                    case (pos[3:2])
                        2'd0:    b = blue[{1'b0, ~pos[1:0]}];
                        2'd1:    b = green[{1'b0, ~pos[1:0]}];
                        default: b = red[{1'b0, ~pos[1:0]}];
                    endcase
                end
            end
            FMT_16:
            begin
                if (pos < 5'd5)
                begin
                    off = 5'd4 - pos;
                    b   = blue[off[2:0]];
                end
                else if (pos < 5'd11)
                begin
                    off = 5'd10 - pos;
                    b   = green[off[2:0]];
                end
                else if (pos < 5'd16)
                begin
                    off = 5'd15 - pos;
                    b   = red[off[2:0]];
                end
            end
            default:
            begin
                // six bits per component, then two zero pad bits
                if (pos < 5'd24 && k < 3'd6)
                begin
                    off = {2'b00, 3'd5 - k};
                    case (pos[4:3])
                        2'd0:    b = blue[off[2:0]];
                        2'd1:    b = green[off[2:0]];
                        default: b = red[off[2:0]];
                    endcase
                end
            end
        endcase
        return b;
    endfunction

    assign pop          = !queue_empty && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign hdr_pos    = bit_pos_reg[2:0];
    assign pos_inc    = {1'b0, bit_pos_reg} + 6'd1;
    assign pixels_dec = pixels_left_reg - 16'd1;

    always_comb
    begin
        case (color_format_reg)
            FMT_12:  pixel_len = 5'd12;
            FMT_16:  pixel_len = 5'd16;
            default: pixel_len = 5'd24;
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PHASE_CASET: hdr_byte = CMD_CASET;
            PHASE_XS_LO: hdr_byte = corners_reg[7:0];
            PHASE_XE_LO: hdr_byte = corners_reg[23:16];
            PHASE_RASET: hdr_byte = CMD_RASET;
            PHASE_YS_LO: hdr_byte = corners_reg[15:8];
            PHASE_YE_LO: hdr_byte = corners_reg[31:24];
            PHASE_RAMWR: hdr_byte = CMD_RAMWR;
            default:     hdr_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        busy_next        = busy_reg;
        phase_next       = phase_reg;
        bit_pos_next     = bit_pos_reg;
        pixels_left_next = pixels_left_reg;
        corners_next     = corners_reg;
        color_next       = color_reg;
        emit             = 1'b0;
        result_next      = result_reg;

        if (pop)
        begin
            if (head.item.op == OP_LOAD)
            begin
                // a load abandons any transfer under way
                corners_next     = {head.item.y_end, head.item.x_end,
                                    head.item.y_start, head.item.x_start};
                color_next       = {head.item.red, head.item.green, head.item.blue};
                pixels_left_next = head.pixel_count;
                busy_next        = 1'b1;
                phase_next       = PHASE_CASET;
                bit_pos_next     = '0;
            end
            else if (busy_reg)
            begin
                emit             = 1'b1;
                result_next.last = 1'b0;
                if (phase_reg < PHASE_PIXELS)
                begin
                    result_next.serial_bit = hdr_byte[3'd7 - hdr_pos];
                    result_next.is_data    = !(phase_reg == PHASE_CASET ||
                                               phase_reg == PHASE_RASET ||
                                               phase_reg == PHASE_RAMWR);
                    if (hdr_pos == 3'd7)
                    begin
                        bit_pos_next = '0;
                        // empty pixel count ends the transfer after the command
                        if (phase_reg == PHASE_RAMWR && pixels_left_reg == 16'd0)
                        begin
                            result_next.last = 1'b1;
                            busy_next        = 1'b0;
                            phase_next       = PHASE_CASET;
                        end
                        else
                        begin
                            phase_next = phase_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        bit_pos_next = {2'b00, hdr_pos} + 5'd1;
                    end
                end
                else
                begin
                    result_next.serial_bit = pixel_bit(color_format_reg, bit_pos_reg,
                                                       color_reg);
                    result_next.is_data    = 1'b1;
                    if (pos_inc >= {1'b0, pixel_len})
                    begin
                        bit_pos_next     = '0;
                        pixels_left_next = pixels_dec;
                        if (pixels_dec == 16'd0)
                        begin
                            result_next.last = 1'b1;
                            busy_next        = 1'b0;
                            phase_next       = PHASE_CASET;
                        end
                    end
                    else
                    begin
                        bit_pos_next = pos_inc[4:0];
                    end
                end
            end
        end

        result_valid_next = emit || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_format_reg <= FMT_RESET;
            busy_reg         <= 1'b0;
            phase_reg        <= PHASE_CASET;
            bit_pos_reg      <= '0;
            pixels_left_reg  <= '0;
            corners_reg      <= '0;
            color_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                color_format_reg <= cfg_wdata;
            end
            busy_reg         <= busy_next;
            phase_reg        <= phase_next;
            bit_pos_reg      <= bit_pos_next;
            pixels_left_reg  <= pixels_left_next;
            corners_reg      <= corners_next;
            color_reg        <= color_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ----- dv/lcd_window_fill_serializer_tb.sv -----
// self-checking testbench for the lcd window fill serializer
`default_nettype none

module lcd_window_fill_serializer_tb;
    import lwfs_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HEADER_BITS  = 88;
    localparam int ITEM_TARGET  = 1900;
    localparam int SETTLE       = 10;
    localparam int LONG_HOLD    = 200;
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    // predicts the serial bit stream and keeps the bits still owed by the block
    class fill_scoreboard;
        logic [1:0]  fmt = FMT_RESET;
        bit          busy = 1'b0;
        logic [3:0]  phase = PHASE_CASET;
        logic [4:0]  bit_pos = '0;
        logic [15:0] pixels_left = '0;
        item_t       window = '0;
        result_t     owed_bits[$];
        int          errors = 0;

        function int pixel_bits();
            case (fmt)
                FMT_12:  return 12;
                FMT_16:  return 16;
                default: return 24;
            endcase
        endfunction

        function int transfer_bits();
            return HEADER_BITS + int'(pixels_left) * pixel_bits();
        endfunction

        function int pending();
            return owed_bits.size();
        endfunction

        function logic [7:0] header_byte(logic [3:0] ph);
            case (ph)
                PHASE_CASET: return CMD_CASET;
                PHASE_XS_LO: return window.x_start;
                PHASE_XE_LO: return window.x_end;
                PHASE_RASET: return CMD_RASET;
                PHASE_YS_LO: return window.y_start;
                PHASE_YE_LO: return window.y_end;
                PHASE_RAMWR: return CMD_RAMWR;
                default:     return 8'h00;
            endcase
        endfunction

        // 0 blue, 1 green, 2 red
        function logic [7:0] component(int idx);
            if (idx == 0)
                return window.blue;
            if (idx == 1)
                return window.green;
            return window.red;
        endfunction

        function logic pixel_bit(int pos);
            logic [7:0] c;
            int k;
            if (fmt == FMT_12)
            begin
                if (pos >= 12)
                    return 1'b0;
                c = component(pos / 4);
                return c[3 - pos % 4];
            end
            if (fmt == FMT_16)
            begin
                c = component(pos < 5 ? 0 : (pos < 11 ? 1 : 2));
                if (pos < 5)
                    return c[4 - pos];
                if (pos < 11)
                    return c[10 - pos];
                if (pos < 16)
                    return c[15 - pos];
                return 1'b0;
            end
            if (pos >= 24)
                return 1'b0;
            k = pos % 8;
            if (k >= 6)
                return 1'b0;
            c = component(pos / 8);
            return c[5 - k];
        endfunction

        // returns 1 when the request yields a serial bit
        function bit note_request(item_t it);
            logic [15:0] w;
            logic [15:0] h;
            logic [31:0] area;
            logic [7:0]  hb;
            result_t r;
            int pos;
            if (it.op == OP_LOAD)
            begin
                w = {8'h00, it.x_end} - {8'h00, it.x_start} + 16'd1;
                h = {8'h00, it.y_end} - {8'h00, it.y_start} + 16'd1;
                area = w * h;
                pixels_left = area[15:0];
                window = it;
                busy = 1'b1;
                phase = PHASE_CASET;
                bit_pos = '0;
                return 1'b0;
            end
            if (!busy)
                return 1'b0;
            r.last = 1'b0;
            if (phase < PHASE_PIXELS)
            begin
                pos = int'(bit_pos[2:0]);
                hb = header_byte(phase);
                r.serial_bit = hb[7 - pos];
                r.is_data = (phase != PHASE_CASET && phase != PHASE_RASET &&
                             phase != PHASE_RAMWR);
                if (pos == 7)
                begin
                    bit_pos = '0;
                    if (phase == PHASE_RAMWR && pixels_left == 16'd0)
                    begin
                        r.last = 1'b1;
                        busy = 1'b0;
                        phase = PHASE_CASET;
                    end
                    else
                        phase = phase + 4'd1;
                end
                else
                    bit_pos = 5'(pos + 1);
            end
            else
            begin
                r.is_data = 1'b1;
                r.serial_bit = pixel_bit(int'(bit_pos));
                if (int'(bit_pos) + 1 >= pixel_bits())
                begin
                    bit_pos = '0;
                    pixels_left = pixels_left - 16'd1;
                    if (pixels_left == 16'd0)
                    begin
                        r.last = 1'b1;
                        busy = 1'b0;
                        phase = PHASE_CASET;
                    end
                end
                else
                    bit_pos = bit_pos + 5'd1;
            end
            owed_bits.push_back(r);
            return 1'b1;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_bits.size() == 0)
            begin
                $error("unexpected result: serial_bit %0b is_data %0b last %0b",
                       got.serial_bit, got.is_data, got.last);
                errors++;
                return;
            end
            want = owed_bits.pop_front();
            if (got.serial_bit !== want.serial_bit)
            begin
                $error("serial_bit: expected %0b, got %0b", want.serial_bit, got.serial_bit);
                errors++;
            end
            if (got.is_data !== want.is_data)
            begin
                $error("is_data: expected %0b, got %0b", want.is_data, got.is_data);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    item_t      item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_wdata = FMT_RESET;

    fill_scoreboard sb = new;
    int cycles = 0;
    int counted = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;

    lcd_window_fill_serializer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random stalls, and one long hold when asked
    initial
    begin
        int pick;
        int len;
        logic stall_val;
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                stall_val = (pick < 25);
                if (pick < 22)
                    len = $urandom_range(1, 3);
                else if (pick < 25)
                    len = $urandom_range(10, 40);
                else
                    len = $urandom_range(1, 30);
                @(negedge clk);
                result_stall <= stall_val;
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    task automatic send(input item_t it);
        @(negedge clk);
        item_valid <= 1'b1;
        item <= it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        void'(sb.note_request(it));
        counted++;
    endtask

    task automatic pause(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic idle_gap();
        int pick;
        if (gaps_on)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 93)
                pause($urandom_range(8, 30));
            else if (pick >= 70)
                pause($urandom_range(1, 3));
        end
    endtask

    task automatic ticks(input int n);
        logic [63:0] noise;
        item_t it;
        repeat (n)
        begin
            noise = {$urandom, $urandom};
            it = noise[56:0];
            it.op = OP_TICK;
            send(it);
            idle_gap();
        end
    endtask

    task automatic load(input logic [7:0] xs, input logic [7:0] ys, input logic [7:0] xe,
                        input logic [7:0] ye, input logic [7:0] r, input logic [7:0] g,
                        input logic [7:0] b);
        item_t it;
        it.op = OP_LOAD;
        it.x_start = xs;
        it.y_start = ys;
        it.x_end = xe;
        it.y_end = ye;
        it.red = r;
        it.green = g;
        it.blue = b;
        send(it);
        idle_gap();
    endtask

    task automatic drain();
        pause(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_format(input logic [1:0] f);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= f;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.fmt = f;
    endtask

    // small window at a random place, or now and then any corners at all
    task automatic random_load(input bit wild);
        int w;
        int h;
        int xs;
        int ys;
        if (wild)
        begin
            load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
        end
        else
        begin
            w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
            h = $urandom_range(1, 3);
            xs = $urandom_range(0, 256 - w);
            ys = $urandom_range(0, 256 - h);
            load(8'(xs), 8'(ys), 8'(xs + w - 1), 8'(ys + h - 1),
                 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int pick;
        int full;
        int n_seq;
        logic [1:0] f;
        int phase_no;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ticks with nothing loaded
        ticks(2);
        load(8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        ticks(sb.transfer_bits() + 2);
        // empty window: x_end just below x_start
        load(8'd10, 8'd20, 8'd9, 8'd20, 8'h12, 8'h34, 8'h56);
        ticks(sb.transfer_bits() + 1);
        // full screen, count wraps to zero
        load(8'd0, 8'd0, 8'd255, 8'd255, 8'hAA, 8'h55, 8'hAA);
        ticks(sb.transfer_bits() + 1);
        // reversed corners, abandoned by a new load
        load(8'd200, 8'd100, 8'd100, 8'd50, 8'h0F, 8'hF0, 8'h81);
        ticks(120);
        load(8'd255, 8'd255, 8'd255, 8'd255, 8'h55, 8'hA5, 8'h3C);
        ticks(sb.transfer_bits() + 1);
        set_format(FMT_12);
        load(8'd3, 8'd4, 8'd4, 8'd4, 8'h5A, 8'hC3, 8'h96);
        ticks(sb.transfer_bits());
        set_format(FMT_18);
        load(8'd7, 8'd7, 8'd7, 8'd7, 8'hE7, 8'h3F, 8'hFC);
        ticks(sb.transfer_bits());
        set_format(FMT_UNUSED);
        load(8'd128, 8'd64, 8'd128, 8'd64, 8'h2A, 8'hD5, 8'h99);
        ticks(sb.transfer_bits());
        // shrink the pixel while the bit position is past the new length
        set_format(FMT_18);
        load(8'd1, 8'd1, 8'd1, 8'd1, 8'hFF, 8'hFF, 8'hFF);
        ticks(HEADER_BITS + 20);
        set_format(FMT_12);
        ticks(6);

        phase_no = 0;
        while (counted < ITEM_TARGET)
        begin
            case (phase_no)
                0:       f = FMT_16;
                1:       f = FMT_18;
                2:       f = FMT_UNUSED;
                3:       f = FMT_12;
                default: f = 2'($urandom_range(0, 3));
            endcase
            set_format(f);
            // carry on whatever transfer was left under way
            ticks($urandom_range(0, 30));
            n_seq = $urandom_range(2, 4);
            repeat (n_seq)
            begin
                gaps_on = ($urandom_range(0, 9) >= 3);
                pick = $urandom_range(0, 99);
                if (phase_no == 0 && !hold_req)
                begin
                    gaps_on = 1'b0;
                    random_load(1'b0);
                    hold_req = 1'b1;
                    ticks(sb.transfer_bits() + 2);
                end
                else if (pick < 70)
                begin
                    random_load(1'b0);
                    ticks(sb.transfer_bits() + $urandom_range(0, 3));
                end
                else if (pick < 85)
                begin
                    random_load(1'b0);
                    full = sb.transfer_bits();
                    ticks($urandom_range(1, full - 1));
                end
                else if (pick < 95)
                begin
                    random_load(1'b1);
                    ticks($urandom_range(20, 150));
                end
                else
                begin
                    ticks($urandom_range(1, 10));
                end
            end
            phase_no++;
        end
        gaps_on = 1'b1;

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- lcd_window_fill_serializer.f -----
design/lwfs_pkg.sv
design/lwfs_front.sv
design/lwfs_queue.sv
design/lwfs_back.sv
design/lcd_window_fill_serializer.sv
dv/lcd_window_fill_serializer_tb.sv
